// ----- rtl/landmark_distance_table_macros.svh -----
// assertion macros for the landmark distance table
// expects signals named clock and reset in the scope of use
`ifndef LANDMARK_DISTANCE_TABLE_MACROS_SVH
`define LANDMARK_DISTANCE_TABLE_MACROS_SVH

// condition holds at every edge out of reset
`define LDT_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define LDT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LDT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ldt_pkg.sv -----
// shared types and constants of the landmark distance table
// used by the channel interfaces, the table memory and the top level
package ldt_pkg;

   localparam int ID_W        = 16;
   localparam int DIST_W      = 16;
   localparam int POS_W       = 16;
   localparam int PORT_W      = 3;
   localparam int MASK_W      = 6;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [DIST_W-1:0] OWN_DIST = 16'd1;

   localparam logic CMD_BEACON = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OWN_ID         = 4'd0,
      CSR_OWN_X          = 4'd1,
      CSR_OWN_Y          = 4'd2,
      CSR_PORT_CONNECTED = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic                     cmd;
      logic [ID_W-1:0]          beacon_id;
      logic [DIST_W-1:0]        beacon_distance;
      logic signed [POS_W-1:0]  beacon_x;
      logic signed [POS_W-1:0]  beacon_y;
      logic [PORT_W-1:0]        arrival_port;
   } req_type;

   typedef struct packed {
      logic                     kept;
      logic [MASK_W-1:0]        send_mask;
      logic [ID_W-1:0]          out_id;
      logic [DIST_W-1:0]        out_distance;
      logic signed [POS_W-1:0]  out_x;
      logic signed [POS_W-1:0]  out_y;
   } rsp_type;

   // position is never read back, so a record holds id and distance
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] distance;
   } entry_type;

endpackage

// ----- rtl/ldt_if.sv -----
// valid/ready channel interfaces for beacon items and result items
// payload types come from ldt_pkg
interface ldt_req_if;
   logic             valid;
   logic             ready;
   ldt_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ldt_rsp_if;
   logic             valid;
   logic             ready;
   ldt_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ldt_table.sv -----
// landmark record memory: one write port, one read port with registered data
// record type from ldt_pkg
module ldt_table #(
   parameter int DEPTH = 10,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ldt_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ldt_pkg::entry_type  rd_data
);

   ldt_pkg::entry_type mem_ff [DEPTH];
   ldt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/landmark_distance_table.sv -----
// A beacon item is taken when the block is idle. An own-beacon tick goes from
// acceptance to the decide state and then into the result register. A received
// beacon walks the stored records through the table's single read port, one id
// compare per cycle, until an id matches or the last record is compared. The
// result sits in an output register, so the next item is taken while it
// waits. The record count is cleared by reset; records need no clearing.
// depends on ldt_pkg, ldt_if, ldt_table and landmark_distance_table_macros.svh
`include "landmark_distance_table_macros.svh"

module landmark_distance_table #(
   parameter int TABLE_DEPTH = 10,
   parameter int PORT_COUNT  = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   ldt_req_if.sink                            req_bus,
   ldt_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [ldt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ldt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [ldt_pkg::MASK_W-1:0] PORT_MASK =
      ldt_pkg::MASK_W'((7'd1 << PORT_COUNT) - 7'd1);
   localparam logic [ldt_pkg::PORT_W-1:0] PORT_LIMIT = ldt_pkg::PORT_W'(PORT_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type                        state_ff, state_in;
   ldt_pkg::req_type                 item_ff, item_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]                    cmp_ptr_ff, cmp_ptr_in;
   logic                             pend_ff, pend_in;
   logic                             hit_ff, hit_in;
   logic [AW-1:0]                    hit_idx_ff, hit_idx_in;
   logic [ldt_pkg::DIST_W-1:0]       hit_dist_ff, hit_dist_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ldt_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic [ldt_pkg::ID_W-1:0]         own_id_ff;
   logic signed [ldt_pkg::POS_W-1:0] own_x_ff;
   logic signed [ldt_pkg::POS_W-1:0] own_y_ff;
   logic [ldt_pkg::MASK_W-1:0]       port_conn_ff;

   logic                             rd_en;
   logic [AW-1:0]                    rd_addr;
   ldt_pkg::entry_type               rd_data;
   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   ldt_pkg::entry_type               wr_data;

   logic                             id_match;
   logic                             last_cmp;
   logic                             slot_free;
   logic                             kept;
   logic [ldt_pkg::MASK_W-1:0]       fwd_mask;
   logic [ldt_pkg::DIST_W-1:0]       fwd_dist;

   ldt_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // the shared id comparator
   assign id_match  = (rd_data.id == item_ff.beacon_id);
   assign last_cmp  = (CW'(cmp_ptr_ff) == (count_ff - CW'(1)));
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      fwd_mask = port_conn_ff & PORT_MASK;
      if (item_ff.arrival_port < PORT_LIMIT) begin
         fwd_mask = fwd_mask & ~(ldt_pkg::MASK_W'(1) << item_ff.arrival_port);
      end
      fwd_dist = (item_ff.beacon_distance == ldt_pkg::DIST_MAX) ? ldt_pkg::DIST_MAX
                 : item_ff.beacon_distance + ldt_pkg::DIST_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      cmp_ptr_in   = cmp_ptr_ff;
      pend_in      = pend_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_dist_in  = hit_dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_ptr_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_data      = '{id: item_ff.beacon_id, distance: item_ff.beacon_distance};
      kept         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               item_in   = req_bus.data;
               rd_ptr_in = '0;
               pend_in   = 1'b0;
               hit_in    = 1'b0;
               if (req_bus.data.cmd == ldt_pkg::CMD_TICK || count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue the next read while the previous record is compared
            if (rd_ptr_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_ptr_in  = rd_ptr_ff + CW'(1);
               cmp_ptr_in = rd_ptr_ff[AW-1:0];
               pend_in    = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && id_match) begin
               hit_in      = 1'b1;
               hit_idx_in  = cmp_ptr_ff;
               hit_dist_in = rd_data.distance;
               state_in    = ST_DECIDE;
            end else if (pend_ff && last_cmp) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (slot_free) begin
               if (item_ff.cmd == ldt_pkg::CMD_TICK) begin
                  rsp_data_in = '{kept: 1'b1, send_mask: port_conn_ff & PORT_MASK,
                                  out_id: own_id_ff, out_distance: ldt_pkg::OWN_DIST,
                                  out_x: own_x_ff, out_y: own_y_ff};
               end else begin
                  if (hit_ff) begin
                     if (item_ff.beacon_distance < hit_dist_ff) begin
                        kept  = 1'b1;
                        wr_en = 1'b1;
                     end
                  end else if (count_ff < DEPTH_C) begin
                     kept     = 1'b1;
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                  end
                  if (kept) begin
                     rsp_data_in = '{kept: 1'b1, send_mask: fwd_mask,
                                     out_id: item_ff.beacon_id, out_distance: fwd_dist,
                                     out_x: item_ff.beacon_x, out_y: item_ff.beacon_y};
                  end else begin
                     rsp_data_in = '0;
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_id_ff    <= '0;
         own_x_ff     <= '0;
         own_y_ff     <= '0;
         port_conn_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               ldt_pkg::CSR_OWN_ID:         own_id_ff    <= csr_wdata;
               ldt_pkg::CSR_OWN_X:          own_x_ff     <= $signed(csr_wdata);
               ldt_pkg::CSR_OWN_Y:          own_y_ff     <= $signed(csr_wdata);
               ldt_pkg::CSR_PORT_CONNECTED: port_conn_ff <= csr_wdata[ldt_pkg::MASK_W-1:0];
               default: begin
               end
            endcase
         end
      end
      item_ff     <= item_in;
      rd_ptr_ff   <= rd_ptr_in;
      cmp_ptr_ff  <= cmp_ptr_in;
      hit_idx_ff  <= hit_idx_in;
      hit_dist_ff <= hit_dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   `LDT_ASSERT(a_count_bound, count_ff <= DEPTH_C, "record count beyond table depth")
   `LDT_ASSERT_IMP(a_write_on_load, wr_en, state_ff == ST_DECIDE && slot_free, "table written outside result load")
   `LDT_ASSERT_NEXT(a_busy_after_accept, req_bus.valid && req_bus.ready, state_ff != ST_IDLE, "idle after taking an item")
   `LDT_ASSERT_NEXT(a_insert_grows, wr_en && !hit_ff, count_ff == $past(count_ff) + CW'(1), "insert did not grow count")
   `LDT_ASSERT_IMP(a_rsp_from_decide, $rose(rsp_bus.valid), $past(state_ff == ST_DECIDE), "result raised outside decision")

endmodule
